// File: rtl/nibble_header_packet_deframer_defines.svh
// assertion macros for the nibble header packet deframer
// used by the top level; expects clk and rst in the including scope
`ifndef NIBBLE_HEADER_PACKET_DEFRAMER_DEFINES_SVH
`define NIBBLE_HEADER_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NHPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NHPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nhpd_pkg.sv
// shared constants, codes and controller/datapath structs for the deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nhpd_pkg;

  // framing bytes
  localparam logic [7:0] START_BYTE  = 8'h80;
  localparam logic [7:0] SYNC_SECOND = 8'h0F;
  localparam logic [7:0] SYNC_THIRD  = 8'h01;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // packet store geometry
  localparam int STORE_DEPTH = 16;
  localparam int STORE_AW    = 4;
  localparam int FILL_W      = 5;
  localparam int ELEM_W      = 8;

  // store write source select
  typedef logic [1:0] wr_src_t;
  localparam wr_src_t SRC_BYTE = 2'd0;
  localparam wr_src_t SRC_CHAN = 2'd1;
  localparam wr_src_t SRC_ZERO = 2'd2;
  localparam wr_src_t SRC_ONE  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic    wr_en;
    logic    wr_restart;
    wr_src_t wr_src;
    logic    len_hdr;
    logic    len_full;
    logic    fill_clear;
    logic    rd_en;
    logic    idx_clear;
    logic    idx_inc;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic link_up;
    logic is_start;
    logic is_sync2;
    logic is_sync3;
    logic hdr_zero;
    logic data_full;
    logic at_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/nhpd_if.sv
// handshake channel interfaces: link input events and packet elements
// depends on nhpd_pkg for the element width
`timescale 1ns / 1ps
`default_nettype none

interface nhpd_link_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface nhpd_elem_if;
  logic                       valid;
  logic                       ready;
  logic [nhpd_pkg::ELEM_W-1:0] element;
  logic                       first;
  logic                       last;

  modport source (output valid, element, first, last, input ready);
  modport sink   (input valid, element, first, last, output ready);
endinterface

`default_nettype wire

// File: rtl/nhpd_ram.sv
// generic single-port-write, registered-read ram
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module nhpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/nhpd_datapath.sv
// deframer datapath: packet store, fill and length counters, output register
// depends on nhpd_pkg and nhpd_ram
`timescale 1ns / 1ps
`default_nettype none

module nhpd_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire nhpd_pkg::dp_cmd_t           cmd,
  input  wire logic                        command,
  input  wire logic [7:0]                  data_byte,
  output nhpd_pkg::dp_status_t             status,
  output logic      [nhpd_pkg::ELEM_W-1:0] element,
  output logic                             first,
  output logic                             last
);

  logic [nhpd_pkg::FILL_W-1:0]   fill_count;
  logic [nhpd_pkg::FILL_W-1:0]   fill_count_next;
  logic [nhpd_pkg::FILL_W-1:0]   fill_inc;
  logic [3:0]                    expected_length;
  logic [nhpd_pkg::STORE_AW-1:0] idx;
  logic [nhpd_pkg::STORE_AW-1:0] wr_addr;
  logic [nhpd_pkg::ELEM_W-1:0]   wr_data;
  logic [nhpd_pkg::ELEM_W-1:0]   rd_data;
  logic                          at_last;

  // saturating element count after one more write
  assign fill_inc = (fill_count == nhpd_pkg::FILL_W'(nhpd_pkg::STORE_DEPTH)) ?
                    fill_count : fill_count + nhpd_pkg::FILL_W'(1);

  // restart writes go to the channel slot
  assign wr_addr = cmd.wr_restart ? '0 : fill_count[nhpd_pkg::STORE_AW-1:0];

  // store write data select
  always_comb begin
    case (cmd.wr_src)
      nhpd_pkg::SRC_CHAN: wr_data = {4'h0, data_byte[7:4]};
      nhpd_pkg::SRC_ZERO: wr_data = '0;
      nhpd_pkg::SRC_ONE:  wr_data = nhpd_pkg::ELEM_W'(1);
      default:            wr_data = data_byte;
    endcase
  end

  // fill count update
  always_comb begin
    fill_count_next = fill_count;
    if (cmd.fill_clear) begin
      fill_count_next = '0;
    end else if (cmd.wr_en) begin
      fill_count_next = cmd.wr_restart ? nhpd_pkg::FILL_W'(1) : fill_inc;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count      <= '0;
      expected_length <= '0;
      idx             <= '0;
    end else begin
      fill_count <= fill_count_next;
      if (cmd.len_hdr) begin
        expected_length <= data_byte[3:0];
      end else if (cmd.len_full) begin
        expected_length <= nhpd_pkg::NIBBLE_MASK;
      end
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + nhpd_pkg::STORE_AW'(1);
      end
    end
  end

  // packet store
  nhpd_ram #(
    .WIDTH (nhpd_pkg::ELEM_W),
    .DEPTH (nhpd_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // element being read is the final one written
  assign at_last = ({1'b0, idx} + nhpd_pkg::FILL_W'(1)) == fill_count;

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      element <= rd_data;
      first   <= (idx == '0);
      last    <= at_last;
    end
  end

  // status back to the controller
  always_comb begin
    status.link_up   = command;
    status.is_start  = (data_byte == nhpd_pkg::START_BYTE);
    status.is_sync2  = (data_byte == nhpd_pkg::SYNC_SECOND);
    status.is_sync3  = (data_byte == nhpd_pkg::SYNC_THIRD);
    status.hdr_zero  = (data_byte[3:0] == 4'h0);
    status.data_full = fill_inc >= ({1'b0, expected_length} + nhpd_pkg::FILL_W'(1));
    status.at_last   = at_last;
  end

endmodule

`default_nettype wire

// File: rtl/nhpd_ctrl.sv
// deframer controller: parse mode tracking and store read-out sequencer
// depends on nhpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module nhpd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire nhpd_pkg::dp_status_t status,
  output nhpd_pkg::dp_cmd_t         cmd
);

  // parse modes
  localparam logic [2:0] MODE_DISCARD = 3'd0;
  localparam logic [2:0] MODE_HEADER  = 3'd1;
  localparam logic [2:0] MODE_DATA    = 3'd2;
  localparam logic [2:0] MODE_SYNC0   = 3'd3;
  localparam logic [2:0] MODE_SYNC1   = 3'd4;
  localparam logic [2:0] MODE_SYNC2   = 3'd5;

  // sequencer states
  localparam logic [2:0] SEQ_IDLE    = 3'd0;
  localparam logic [2:0] SEQ_PRELOAD = 3'd1;
  localparam logic [2:0] SEQ_READ    = 3'd2;
  localparam logic [2:0] SEQ_LOAD    = 3'd3;
  localparam logic [2:0] SEQ_SHOW    = 3'd4;

  logic [2:0] mode;
  logic [2:0] mode_next;
  logic [2:0] seq;
  logic [2:0] seq_next;
  logic       accept;

  assign in_ready  = (seq == SEQ_IDLE);
  assign out_valid = (seq == SEQ_SHOW);
  assign accept    = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    mode_next = mode;
    seq_next  = seq;
    cmd       = '0;
    unique case (seq)
      SEQ_IDLE: begin
        if (accept) begin
          if (status.link_up) begin
            mode_next      = MODE_SYNC0;
            cmd.fill_clear = 1'b1;
          end else begin
            unique case (mode)
              MODE_SYNC0: begin
                if (status.is_start) begin
                  mode_next = MODE_SYNC1;
                end
              end
              MODE_SYNC1: begin
                if (status.is_sync2) begin
                  mode_next = MODE_SYNC2;
                end else if (!status.is_start) begin
                  mode_next = MODE_SYNC0;
                end
              end
              MODE_SYNC2: begin
                if (status.is_sync3) begin
                  // channel zero now, the 0x01 byte in the next cycle
                  mode_next      = MODE_DATA;
                  cmd.len_full   = 1'b1;
                  cmd.wr_en      = 1'b1;
                  cmd.wr_restart = 1'b1;
                  cmd.wr_src     = nhpd_pkg::SRC_ZERO;
                  seq_next       = SEQ_PRELOAD;
                end else if (status.is_start) begin
                  mode_next = MODE_SYNC1;
                end else begin
                  mode_next = MODE_SYNC0;
                end
              end
              MODE_HEADER: begin
                cmd.len_hdr    = 1'b1;
                cmd.wr_en      = 1'b1;
                cmd.wr_restart = 1'b1;
                cmd.wr_src     = nhpd_pkg::SRC_CHAN;
                if (status.hdr_zero) begin
                  mode_next     = MODE_DISCARD;
                  cmd.idx_clear = 1'b1;
                  seq_next      = SEQ_READ;
                end else begin
                  mode_next = MODE_DATA;
                end
              end
              MODE_DATA: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = nhpd_pkg::SRC_BYTE;
                if (status.data_full) begin
                  mode_next     = MODE_DISCARD;
                  cmd.idx_clear = 1'b1;
                  seq_next      = SEQ_READ;
                end
              end
              default: begin
                // discard and unused codes wait for a start byte
                mode_next = status.is_start ? MODE_HEADER : MODE_DISCARD;
              end
            endcase
          end
        end
      end
      SEQ_PRELOAD: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = nhpd_pkg::SRC_ONE;
        seq_next   = SEQ_IDLE;
      end
      SEQ_READ: begin
        cmd.rd_en = 1'b1;
        seq_next  = SEQ_LOAD;
      end
      SEQ_LOAD: begin
        cmd.out_load = 1'b1;
        seq_next     = SEQ_SHOW;
      end
      SEQ_SHOW: begin
        if (out_ready) begin
          if (status.at_last) begin
            cmd.fill_clear = 1'b1;
            seq_next       = SEQ_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            seq_next    = SEQ_READ;
          end
        end
      end
      default: begin
        seq_next = SEQ_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DISCARD;
      seq  <= SEQ_IDLE;
    end else begin
      mode <= mode_next;
      seq  <= seq_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/nibble_header_packet_deframer.sv
// channel   | dir | payload                  | handshake
// link      | in  | command, data_byte       | valid/ready
// packet    | out | element, first, last     | valid/ready
//
// a link event is taken whenever the block is idle
// a sync match adds a preload state that writes the second element
// a finished packet drains through the read, load and show states per element plus output stalls;
// link ready stays low until the last element is taken
// synchronous active-high reset; the packet store needs no clearing pass
//
// top level: joins controller and datapath; depends on nhpd_pkg, nhpd_if,
// nhpd_ctrl, nhpd_datapath and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "nibble_header_packet_deframer_defines.svh"

module nibble_header_packet_deframer (
  input wire logic      clk,
  input wire logic      rst,
  nhpd_link_if.sink     link,
  nhpd_elem_if.source   packet
);

  nhpd_pkg::dp_cmd_t    cmd;
  nhpd_pkg::dp_status_t status;

  // controller
  nhpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (link.valid),
    .in_ready  (link.ready),
    .out_valid (packet.valid),
    .out_ready (packet.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  nhpd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .command   (link.command),
    .data_byte (link.data_byte),
    .status    (status),
    .element   (packet.element),
    .first     (packet.first),
    .last      (packet.last)
  );

  // input is never taken while an element is offered
  `NHPD_ASSERT_NOW(a_no_overlap, packet.valid, !link.ready, "ready while emitting")
  // the store is never written during read-out
  `NHPD_ASSERT_NOW(a_no_wr_emit, cmd.wr_en, !packet.valid, "store write during emit")
  // the opening element carries a channel number
  `NHPD_ASSERT_NOW(a_first_chan, packet.valid && packet.first,
                   packet.element[7:4] == 4'h0, "first element is not a channel")
  // the final transaction of a packet returns the block to idle
  `NHPD_ASSERT_NEXT(a_last_idle, packet.valid && packet.ready && packet.last,
                    link.ready, "not idle after packet end")

endmodule

`default_nettype wire
